[hdl/tctt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tctt_pkg;

	// 273.15 K in Q16.16
	localparam logic [24:0] KELV_Q16 = 25'd17901158;
	// kelvin magnitude clamp, Q16.16
	localparam logic [27:0] KMAX_Q16 = 28'hFFFFFFF;
	localparam logic [15:0] CODE_LIMIT = 16'h4000;
	localparam logic signed [30:0] OUT_MAX = 31'sd524287;
	localparam logic signed [30:0] OUT_MIN = -31'sd524288;

	// square root pipeline: two result bits per stage, 32 bits of root
	localparam int SQ_STAGES = 16;

	typedef enum logic [2:0] {
		REG_CODE_OFFSET    = 3'd0,
		REG_SLOPE_NORM     = 3'd1,
		REG_INTERCEPT_NORM = 3'd2,
		REG_HALF_RATIO     = 3'd3,
		REG_ENV_DIVIDEND   = 3'd4,
		REG_ENV_DIVISOR    = 3'd5,
		REG_OUT_GAIN       = 3'd6,
		REG_OUT_OFFSET     = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic [15:0] code_offset;
		logic [31:0] slope_norm;
		logic [31:0] intercept_norm;
		logic [31:0] half_ratio;
		logic [47:0] env_dividend;
		logic [31:0] env_divisor;
		logic [15:0] out_gain;
		logic [23:0] out_offset;
	} cfg_t;

	// per-beat control traveling with the data
	typedef struct packed {
		logic vld;
		logic err;
	} beat_t;

	typedef struct packed {
		logic [33:0] rem;
		logic [31:0] root;
	} sq_t;

	// one restoring square root iteration
	function automatic sq_t sq_step(input sq_t cur, input logic [1:0] bits);
		logic [35:0] r2;
		logic [35:0] trial;
		sq_t nxt;
		r2 = {cur.rem, bits};
		trial = {2'b00, cur.root, 2'b01};
		if (r2 >= trial) begin
			nxt.rem = 34'(r2 - trial);
			nxt.root = {cur.root[30:0], 1'b1};
		end else begin
			nxt.rem = r2[33:0];
			nxt.root = {cur.root[30:0], 1'b0};
		end
		return nxt;
	endfunction

endpackage

`default_nettype wire

[hdl/tctt_sqrt.sv]
`timescale 1ns / 1ps
`default_nettype none

module tctt_sqrt import tctt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire beat_t       in_beat,
	input  wire logic [63:0] radicand,
	output beat_t            out_beat,
	output logic [31:0]      root
);

	beat_t       beat_s [SQ_STAGES];
	logic [63:0] rad_s  [SQ_STAGES];
	sq_t         acc_s  [SQ_STAGES];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		beat_t       b_in;
		logic [63:0] r_in;
		sq_t         a_in;
		sq_t         a_mid;
		sq_t         a_out;

		if (g == 0) begin : g_first
			assign b_in = in_beat;
			assign r_in = radicand;
			assign a_in = '0;
		end else begin : g_next
			assign b_in = beat_s[g-1];
			assign r_in = rad_s[g-1];
			assign a_in = acc_s[g-1];
		end

		assign a_mid = sq_step(a_in, r_in[63:62]);
		assign a_out = sq_step(a_mid, r_in[61:60]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				beat_s[g] <= '0;
			end else if (en) begin
				beat_s[g] <= b_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g] <= {r_in[59:0], 4'b0000};
				acc_s[g] <= a_out;
			end
		end
	end

	assign out_beat = beat_s[SQ_STAGES-1];
	assign root     = acc_s[SQ_STAGES-1].root;

endmodule

`default_nettype wire

[hdl/tctt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module tctt_front import tctt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire cfg_t        cfg,
	input  wire logic        code_valid,
	input  wire logic [15:0] raw_code,
	output beat_t            out_beat,
	output logic [63:0]      radicand
);

	logic signed [63:0] hsq;
	logic [46:0]        hh_q;

	beat_t              beat_s1;
	beat_t              beat_s2;
	beat_t              beat_s3;
	logic signed [17:0] d_s1;
	logic signed [49:0] prod_s2;
	logic [47:0]        rad_s3;

	logic signed [17:0] d_n;
	logic [51:0]        rad_n;

	// h*h floor to Q16.16; user must keep config static while beats are in flight (not enforced)
	assign hsq = $signed(cfg.half_ratio) * $signed(cfg.half_ratio);

	always_ff @(posedge clk) begin
		hh_q <= hsq[62:16];
	end

	assign d_n = $signed({2'b00, raw_code}) - $signed({2'b00, cfg.code_offset});

	assign rad_n = {{2{prod_s2[49]}}, prod_s2}
		+ {{20{cfg.intercept_norm[31]}}, cfg.intercept_norm}
		+ {5'b00000, hh_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s1 <= '0;
			beat_s2 <= '0;
			beat_s3 <= '0;
		end else if (en) begin
			beat_s1.vld <= code_valid;
			beat_s1.err <= (raw_code >= CODE_LIMIT);
			beat_s2 <= beat_s1;
			beat_s3.vld <= beat_s2.vld;
			beat_s3.err <= beat_s2.err | rad_n[51];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1    <= d_n;
			prod_s2 <= d_s1 * $signed(cfg.slope_norm);
			rad_s3  <= rad_n[47:0];
		end
	end

	assign out_beat = beat_s3;
	assign radicand = {rad_s3, 16'h0000};

endmodule

`default_nettype wire

[hdl/tctt_rad.sv]
`timescale 1ns / 1ps
`default_nettype none

module tctt_rad import tctt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire cfg_t        cfg,
	input  wire beat_t       in_beat,
	input  wire logic [31:0] root,
	output beat_t            out_beat,
	output logic [63:0]      power
);

	beat_t       beat_s4;
	beat_t       beat_s5;
	beat_t       beat_s6;
	beat_t       beat_s7;
	beat_t       beat_s8;
	beat_t       beat_s9;
	logic [27:0] ka_s4;
	logic [31:0] k2_s5;
	logic [63:0] k4_s6;
	logic [63:0] diff_s7;
	logic [63:0] ph_s8;
	logic [39:0] pl_s8;
	logic [63:0] p_s9;

	logic [34:0] k_n;
	logic [34:0] kmag;
	logic [27:0] ka_n;
	logic [55:0] ksq;
	logic [63:0] div16;
	logic [63:0] plfull;
	logic [64:0] sum;

	// K = r + 273.15, r = root - h
	assign k_n = {3'b000, root} + {10'd0, KELV_Q16}
		- {{3{cfg.half_ratio[31]}}, cfg.half_ratio};
	assign kmag = k_n[34] ? 35'(-k_n) : k_n;
	assign ka_n = (kmag > {7'd0, KMAX_Q16}) ? KMAX_Q16 : kmag[27:0];

	assign ksq    = ka_s4 * ka_s4;
	assign div16  = {cfg.env_dividend, 16'h0000};
	assign plfull = diff_s7[31:0] * cfg.env_divisor;
	assign sum    = {1'b0, ph_s8[55:0], 8'h00} + {25'd0, pl_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s4 <= '0;
			beat_s5 <= '0;
			beat_s6 <= '0;
			beat_s7 <= '0;
			beat_s8 <= '0;
			beat_s9 <= '0;
		end else if (en) begin
			beat_s4 <= in_beat;
			beat_s5 <= beat_s4;
			beat_s6 <= beat_s5;
			beat_s7 <= beat_s6;
			beat_s8 <= beat_s7;
			beat_s9 <= beat_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ka_s4   <= ka_n;
			k2_s5   <= ksq[55:24];
			k4_s6   <= k2_s5 * k2_s5;
			diff_s7 <= (k4_s6 > div16) ? (k4_s6 - div16) : 64'd0;
			ph_s8   <= diff_s7[63:32] * cfg.env_divisor;
			pl_s8   <= plfull[63:24];
			// saturate the Q48.16 product at all ones
			p_s9    <= ((|ph_s8[63:56]) || sum[64]) ? '1 : sum[63:0];
		end
	end

	assign out_beat = beat_s9;
	assign power    = p_s9;

endmodule

`default_nettype wire

[hdl/tctt_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module tctt_out import tctt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire cfg_t        cfg,
	input  wire beat_t       in_beat,
	input  wire logic [31:0] root,
	output logic             result_valid,
	output logic [19:0]      temperature,
	output logic             range_error
);

	beat_t              beat_s10;
	logic signed [50:0] v_s10;

	logic signed [33:0] t_n;
	logic [51:0]        vr;
	logic signed [30:0] res;
	logic signed [30:0] sat;

	assign t_n = $signed({2'b00, root}) - $signed({9'd0, KELV_Q16});

	// round half up from Q.30 to 1/256 degC
	assign vr  = {v_s10[50], v_s10} + 52'h0000000200000;
	assign res = $signed({vr[51], vr[51:22]})
		+ $signed({{7{cfg.out_offset[23]}}, cfg.out_offset});

	always_comb begin
		priority if (res > OUT_MAX) begin
			sat = OUT_MAX;
		end else if (res < OUT_MIN) begin
			sat = OUT_MIN;
		end else begin
			sat = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_s10     <= '0;
			result_valid <= 1'b0;
		end else if (en) begin
			beat_s10     <= in_beat;
			result_valid <= beat_s10.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s10       <= t_n * $signed({1'b0, cfg.out_gain});
			range_error <= beat_s10.err;
			temperature <= beat_s10.err ? 20'd0 : sat[19:0];
		end
	end

endmodule

`default_nettype wire

[hdl/thermal_code_to_temperature.sv]
// Radiometric code to temperature converter.
// Input channel code_valid/code_ready carries one raw_code beat; output
// channel result_valid/result_ready carries temperature (1/256 degC, signed,
// saturated) and range_error. Codes of 0x4000 and up, or a negative
// radicand, give temperature 0 with range_error set.
// Throughput: one beat per cycle, sustained, while the output is not stalled.
// Pipeline: from input accept to result_valid a beat passes three 16-stage
// square root pipelines (two root bits per stage) plus eleven stages of
// multiply, add and saturate logic.
// Stall: all stages share one enable, high while the output register is
// empty or being taken; code_ready follows it, so a held result freezes
// the whole pipe and nothing is dropped or duplicated.
// Config: cfg_we/cfg_index/cfg_data write a register; write
// only while the pipe is empty.
// Reset: arst_n clears valid bits and loads register defaults.
`timescale 1ns / 1ps
`default_nettype none

module thermal_code_to_temperature import tctt_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [47:0] cfg_data,
	input  wire logic        code_valid,
	output logic             code_ready,
	input  wire logic [15:0] raw_code,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [19:0]      temperature,
	output logic             range_error
);

	cfg_t        cfg_q;
	logic        en;
	beat_t       front_beat;
	beat_t       sq1_beat;
	beat_t       rad_beat;
	beat_t       sq2_beat;
	beat_t       sq3_beat;
	logic [63:0] radicand;
	logic [31:0] root1;
	logic [63:0] power;
	logic [31:0] root2;
	logic [31:0] root3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_offset    <= 16'd0;
			cfg_q.slope_norm     <= 32'd65536;
			cfg_q.intercept_norm <= 32'd0;
			cfg_q.half_ratio     <= 32'd0;
			cfg_q.env_dividend   <= 48'd0;
			cfg_q.env_divisor    <= 32'd16777216;
			cfg_q.out_gain       <= 16'd16384;
			cfg_q.out_offset     <= 24'd0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CODE_OFFSET:    cfg_q.code_offset    <= cfg_data[15:0];
				REG_SLOPE_NORM:     cfg_q.slope_norm     <= cfg_data[31:0];
				REG_INTERCEPT_NORM: cfg_q.intercept_norm <= cfg_data[31:0];
				REG_HALF_RATIO:     cfg_q.half_ratio     <= cfg_data[31:0];
				REG_ENV_DIVIDEND:   cfg_q.env_dividend   <= cfg_data;
				REG_ENV_DIVISOR:    cfg_q.env_divisor    <= cfg_data[31:0];
				REG_OUT_GAIN:       cfg_q.out_gain       <= cfg_data[15:0];
				REG_OUT_OFFSET:     cfg_q.out_offset     <= cfg_data[23:0];
			endcase
		end
	end

	assign en         = !result_valid || result_ready;
	assign code_ready = en;

	tctt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.cfg        (cfg_q),
		.code_valid (code_valid),
		.raw_code   (raw_code),
		.out_beat   (front_beat),
		.radicand   (radicand)
	);

	tctt_sqrt u_sqrt_r (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_beat  (front_beat),
		.radicand (radicand),
		.out_beat (sq1_beat),
		.root     (root1)
	);

	tctt_rad u_rad (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.cfg      (cfg_q),
		.in_beat  (sq1_beat),
		.root     (root1),
		.out_beat (rad_beat),
		.power    (power)
	);

	// fourth root as two chained square roots
	tctt_sqrt u_sqrt_p (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_beat  (rad_beat),
		.radicand (power),
		.out_beat (sq2_beat),
		.root     (root2)
	);

	tctt_sqrt u_sqrt_t (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_beat  (sq2_beat),
		.radicand ({8'h00, root2, 24'h000000}),
		.out_beat (sq3_beat),
		.root     (root3)
	);

	tctt_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg_q),
		.in_beat      (sq3_beat),
		.root         (root3),
		.result_valid (result_valid),
		.temperature  (temperature),
		.range_error  (range_error)
	);

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && range_error |-> temperature == 20'd0)
		else $error("range error beat with nonzero temperature");

	a_reset_empty: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !result_valid)
		else $error("result valid right after reset");

	a_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !range_error && cfg_q.out_gain == 16'd0
		&& $signed(cfg_q.out_offset) >= -24'sd524288
		&& $signed(cfg_q.out_offset) <= 24'sd524287
		|-> temperature == cfg_q.out_offset[19:0])
		else $error("zero gain does not yield the offset");
`endif

endmodule

`default_nettype wire
